/* hdl/packed_pixel_to_rgb_converter_core_macros.svh */
// Assertion helpers used by the converter's back stage (ppr_back).
`ifndef PACKED_PIXEL_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define PACKED_PIXEL_TO_RGB_CONVERTER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one in the following cycle.
`define PPR_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* hdl/ppr_pkg.sv */
package ppr_pkg;

  typedef enum logic [1:0] {
    FMT_MONO   = 2'd0,
    FMT_DUAL   = 2'd1,
    FMT_PACKED = 2'd2,
    FMT_RGB565 = 2'd3
  } fmt_t;

  localparam logic [1:0] REG_SOURCE_FORMAT  = 2'd0;
  localparam logic [1:0] REG_PICTURE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_PICTURE_HEIGHT = 2'd2;

  localparam int unsigned CFG_W = 11;

  localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;
  localparam logic [23:0] RGB_LIGHT = 24'hAAAAAA;
  localparam logic [23:0] RGB_DARK  = 24'h777777;
  localparam logic [23:0] RGB_BLACK = 24'h000000;

  // Last pixel index of each source format.
  localparam logic [2:0] LAST_IDX_1BIT   = 3'd7;
  localparam logic [2:0] LAST_IDX_PACKED = 3'd1;
  localparam logic [2:0] LAST_IDX_RGB565 = 3'd0;

  // One classified input transaction waiting for expansion.
  typedef struct packed {
    fmt_t       fmt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [2:0] last_idx;
  } item_t;

  function automatic logic [23:0] gray_lookup(input logic [1:0] code);
    logic [23:0] rgb;
    unique case (code)
      2'd0:    rgb = RGB_WHITE;
      2'd1:    rgb = RGB_LIGHT;
      2'd2:    rgb = RGB_DARK;
      default: rgb = RGB_BLACK;
    endcase
    return rgb;
  endfunction

endpackage

/* hdl/ppr_front.sv */
module ppr_front (
  input  logic            clk,
  input  logic            rst,
  input  ppr_pkg::fmt_t   source_format,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      plane0_byte,
  input  logic [7:0]      plane1_byte,
  output logic            q_valid,
  output ppr_pkg::item_t  q_head,
  input  logic            q_pop
);

  ppr_pkg::item_t entries [2];
  ppr_pkg::item_t new_item;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  // Tag each transaction with the last pixel index its format implies.
  always_comb begin
    new_item.fmt = source_format;
    new_item.b0  = plane0_byte;
    new_item.b1  = plane1_byte;
    unique case (source_format)
      ppr_pkg::FMT_MONO,
      ppr_pkg::FMT_DUAL:   new_item.last_idx = ppr_pkg::LAST_IDX_1BIT;
      ppr_pkg::FMT_PACKED: new_item.last_idx = ppr_pkg::LAST_IDX_PACKED;
      default:             new_item.last_idx = ppr_pkg::LAST_IDX_RGB565;
    endcase
  end

  // Hold ready low during reset so no transaction is taken and then lost.
  assign in_ready = !rst && (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/ppr_back.sv */
`include "packed_pixel_to_rgb_converter_core_macros.svh"

module ppr_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ppr_pkg::CFG_W-1:0]  picture_width,
  input  logic [ppr_pkg::CFG_W-1:0]  picture_height,
  input  logic                       q_valid,
  input  ppr_pkg::item_t             q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [23:0]                pixel_rgb,
  output logic                       last_of_item,
  output logic                       end_of_frame
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = (CW + 1 > ppr_pkg::CFG_W) ? CW + 1 : ppr_pkg::CFG_W;
  localparam int DH = (RW + 1 > ppr_pkg::CFG_W) ? RW + 1 : ppr_pkg::CFG_W;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [2:0]    k;
  logic [DW-1:0] w_eff;
  logic [DH-1:0] h_eff;
  logic [DW-1:0] col_inc;
  logic [DH-1:0] row_inc;
  logic          row_end;
  logic          eof;
  logic          fire;
  logic          last;
  logic [2:0]    sh;
  logic [3:0]    nib;
  logic [23:0]   rgb;

  // Clamp the dimensions to 1..max.
  always_comb begin
    priority if (picture_width == '0) begin
      w_eff = DW'(1);
    end else if (DW'(picture_width) > DW'(MAX_WIDTH)) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(picture_width);
    end
    priority if (picture_height == '0) begin
      h_eff = DH'(1);
    end else if (DH'(picture_height) > DH'(MAX_HEIGHT)) begin
      h_eff = DH'(MAX_HEIGHT);
    end else begin
      h_eff = DH'(picture_height);
    end
  end

  assign col_inc = DW'(col) + DW'(1);
  assign row_inc = DH'(row) + DH'(1);
  assign row_end = (col_inc >= w_eff);
  assign eof     = row_end && (row_inc >= h_eff);

  assign sh  = 3'(3'd7 - k);
  assign nib = (k == 3'd0) ? q_head.b0[7:4] : q_head.b0[3:0];

  always_comb begin
    unique case (q_head.fmt)
      ppr_pkg::FMT_MONO: begin
        rgb = q_head.b0[sh] ? ppr_pkg::RGB_BLACK : ppr_pkg::RGB_WHITE;
      end
      ppr_pkg::FMT_DUAL: begin
        rgb = ppr_pkg::gray_lookup({q_head.b0[sh], q_head.b1[sh]});
      end
      ppr_pkg::FMT_PACKED: begin
        rgb = {{8{nib[3]}}, {8{nib[2]}}, {8{nib[1]}}};
      end
      default: begin
        rgb = {q_head.b0[7:3], 3'b000,
               q_head.b0[2:0], q_head.b1[7:5], 2'b00,
               q_head.b1[4:0], 3'b000};
      end
    endcase
  end

  // The 1-bit formats stop at row end, packed stops at frame end, RGB565 after one pixel.
  always_comb begin
    last = (k == q_head.last_idx);
    unique case (q_head.fmt)
      ppr_pkg::FMT_MONO,
      ppr_pkg::FMT_DUAL:   last = last || row_end;
      ppr_pkg::FMT_PACKED: last = last || eof;
      default:             last = 1'b1;
    endcase
  end

  assign fire  = q_valid && (!out_valid || out_ready);
  assign q_pop = fire && last;

  always_ff @(posedge clk) begin
    if (fire) begin
      pixel_rgb    <= rgb;
      last_of_item <= last;
      end_of_frame <= eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      col       <= '0;
      row       <= '0;
      k         <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        k         <= last ? 3'd0 : k + 3'd1;
        if (row_end) begin
          col <= '0;
          row <= eof ? '0 : row_inc[RW-1:0];
        end else begin
          col <= col_inc[CW-1:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PPR_ASSERT(a_idx_in_range, !q_valid || (k <= q_head.last_idx), "pixel index past item end")
  `PPR_ASSERT(a_eof_is_last, !out_valid || !end_of_frame || last_of_item, "frame end not item end")
  `PPR_ASSERT(a_col_bound, DW'(col) < DW'(MAX_WIDTH), "column counter out of range")
  `PPR_ASSERT_NEXT(a_eof_wrap, fire && eof, (col == '0) && (row == '0), "counters did not wrap")

endmodule

/* hdl/packed_pixel_to_rgb_converter_core.sv */
// A transaction's first pixel passes through a queue entry, then the output register.
// Throughput: one pixel per cycle from the expansion stage unless the output
// stalls; a transaction yields 1 pixel (R5G6B5), 1-2 (packed 4-bit) or 1-8 (1-bit, up to row end).
// A 2-entry queue lets input run ahead while the expansion stage is busy.
// Reset (rst, synchronous): empties the queue and output, zeroes the counters,
// and restores format mono, width 128, height 64.
module packed_pixel_to_rgb_converter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [ppr_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                plane0_byte,
  input  logic [7:0]                plane1_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [23:0]               pixel_rgb,
  output logic                      last_of_item,
  output logic                      end_of_frame
);

  ppr_pkg::fmt_t              source_format;
  logic [ppr_pkg::CFG_W-1:0]  picture_width;
  logic [ppr_pkg::CFG_W-1:0]  picture_height;
  logic                       q_valid;
  logic                       q_pop;
  ppr_pkg::item_t             q_head;

  // Configuration writes are never stalled and take effect at the next clock edge; hold ready low during reset.
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format  <= ppr_pkg::FMT_MONO;
      picture_width  <= ppr_pkg::CFG_W'(128);
      picture_height <= ppr_pkg::CFG_W'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ppr_pkg::REG_SOURCE_FORMAT:  source_format  <= ppr_pkg::fmt_t'(cfg_data[1:0]);
        ppr_pkg::REG_PICTURE_WIDTH:  picture_width  <= cfg_data;
        ppr_pkg::REG_PICTURE_HEIGHT: picture_height <= cfg_data;
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // Front: accept and classify transactions into the queue.
  ppr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .source_format (source_format),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .plane0_byte   (plane0_byte),
    .plane1_byte   (plane1_byte),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop)
  );

  // Back: expand the queue head one pixel per cycle unless the output stalls, and track position.
  ppr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .picture_width  (picture_width),
    .picture_height (picture_height),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_rgb      (pixel_rgb),
    .last_of_item   (last_of_item),
    .end_of_frame   (end_of_frame)
  );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int PIC_MAX_W = 1024;
  localparam int PIC_MAX_H = 1024;
  // Index 3 decodes to no register; writes to it must change nothing.
  localparam logic [1:0] REG_SPARE = 2'd3;
  // Cycles the receiver holds off during the backpressure stretch.
  localparam int unsigned LONG_HOLD = 150;

  // One expected output pixel.
  typedef struct packed {
    logic [23:0] rgb;
    logic        last;
    logic        eof;
  } px_t;

  // One row of the directed script: a register write or a byte pair,
  // optionally with the single pixel it must give typed in by hand.
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  idx;
    logic [10:0] data;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        known;
    logic [23:0] rgb;
    logic        eof;
  } step_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = '0;
  logic [ppr_pkg::CFG_W-1:0] cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                plane0_byte = '0;
  logic [7:0]                plane1_byte = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [23:0]               pixel_rgb;
  logic                      last_of_item;
  logic                      end_of_frame;

  // Hand-typed expectation that travels with the byte pair on offer.
  logic              cur_known = 1'b0;
  logic [23:0]       cur_rgb = '0;
  logic              cur_eof = 1'b0;

  // Idle odds in percent per cycle for the sender and the receiver.
  int unsigned       tx_idle_pct = 36;
  int unsigned       rx_idle_pct = 66;

  // Long hold-off requests from the stimulus; the receiver serves them.
  int unsigned       hold_req = 0;
  int unsigned       hold_done = 0;
  int unsigned       hold_left = 0;

  // Shadow of the converter: settings and raster position.
  ppr_pkg::fmt_t     m_fmt = ppr_pkg::FMT_MONO;
  logic [10:0]       m_width = 11'd128;
  logic [10:0]       m_height = 11'd64;
  int unsigned       m_col = 0;
  int unsigned       m_row = 0;

  px_t               expected_px[$];
  step_t             script[$];

  int unsigned       mismatches = 0;
  int unsigned       items_taken = 0;
  int unsigned       px_taken = 0;
  int unsigned       frames_seen = 0;
  int unsigned       writes_taken = 0;

  packed_pixel_to_rgb_converter_core #(
    .MAX_WIDTH (PIC_MAX_W),
    .MAX_HEIGHT(PIC_MAX_H)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .plane0_byte (plane0_byte),
    .plane1_byte (plane1_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_rgb   (pixel_rgb),
    .last_of_item(last_of_item),
    .end_of_frame(end_of_frame)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------

  // Zero counts as 1, anything above the maximum counts as the maximum.
  function automatic int unsigned usable_dim(logic [10:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  // Advance the raster by one pixel; flag a row end, return the frame end.
  // A row ends once the column reaches or passes the width, so a width cut
  // mid-row takes effect on the next pixel.
  function automatic logic advance_raster(output logic row_done);
    row_done = 1'b0;
    m_col++;
    if (m_col >= usable_dim(m_width, PIC_MAX_W)) begin
      m_col = 0;
      row_done = 1'b1;
      m_row++;
      if (m_row >= usable_dim(m_height, PIC_MAX_H)) begin
        m_row = 0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Expand one byte pair into the pixels it yields under the current format,
  // append them to the expected queue and return how many there were.
  function automatic int unsigned expand_bytes(logic [7:0] b0, logic [7:0] b1);
    px_t         burst[8];
    int unsigned n;
    int          k;
    logic        row_done;
    logic        stop;
    logic [3:0]  nib;
    logic [15:0] raw;
    logic [23:0] rgb;
    n = 0;
    stop = 1'b0;
    case (m_fmt)
      ppr_pkg::FMT_MONO, ppr_pkg::FMT_DUAL: begin
        // Always start at the MSB; stop at the row end, dropping the padding.
        for (k = 7; k >= 0 && !stop; k--) begin
          if (m_fmt == ppr_pkg::FMT_MONO) begin
            rgb = b0[k] ? ppr_pkg::RGB_BLACK : ppr_pkg::RGB_WHITE;
          end else begin
            case ({b0[k], b1[k]})
              2'b00:   rgb = ppr_pkg::RGB_WHITE;
              2'b01:   rgb = ppr_pkg::RGB_LIGHT;
              2'b10:   rgb = ppr_pkg::RGB_DARK;
              default: rgb = ppr_pkg::RGB_BLACK;
            endcase
          end
          burst[n].rgb = rgb;
          burst[n].last = 1'b0;
          burst[n].eof = advance_raster(row_done);
          stop = row_done;
          n++;
        end
      end
      ppr_pkg::FMT_PACKED: begin
        // High nibble first; a frame end on it drops the low nibble.
        for (k = 0; k < 2 && !stop; k++) begin
          nib = (k == 0) ? b0[7:4] : b0[3:0];
          burst[n].rgb = {{8{nib[3]}}, {8{nib[2]}}, {8{nib[1]}}};
          burst[n].last = 1'b0;
          burst[n].eof = advance_raster(row_done);
          stop = burst[n].eof;
          n++;
        end
      end
      default: begin
        raw = {b0, b1};
        burst[0].rgb = {raw[15:11], 3'b000, raw[10:5], 2'b00, raw[4:0], 3'b000};
        burst[0].last = 1'b0;
        burst[0].eof = advance_raster(row_done);
        n = 1;
      end
    endcase
    burst[n - 1].last = 1'b1;
    for (k = 0; k < n; k++) expected_px.push_back(burst[k]);
    return n;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: everything here samples the values from just before the edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    px_t         want;
    int unsigned n;
    if (rst) begin
      m_fmt = ppr_pkg::FMT_MONO;
      m_width = 11'd128;
      m_height = 11'd64;
      m_col = 0;
      m_row = 0;
    end else begin
      // Check the outgoing pixel before queuing anything new this edge.
      if (out_valid && out_ready) begin
        px_taken++;
        if (end_of_frame) frames_seen++;
        if (expected_px.size() == 0) begin
          mismatches++;
          $display("%0t: pixel expected none actual rgb %h last %b eof %b",
                   $time, pixel_rgb, last_of_item, end_of_frame);
        end else begin
          want = expected_px.pop_front();
          if (pixel_rgb !== want.rgb) begin
            mismatches++;
            $display("%0t: pixel_rgb expected %h actual %h", $time, want.rgb, pixel_rgb);
          end
          if (last_of_item !== want.last) begin
            mismatches++;
            $display("%0t: last_of_item expected %b actual %b",
                     $time, want.last, last_of_item);
          end
          if (end_of_frame !== want.eof) begin
            mismatches++;
            $display("%0t: end_of_frame expected %b actual %b",
                     $time, want.eof, end_of_frame);
          end
        end
      end

      // Mirror register writes; unused format bits and the unmapped index are dropped.
      if (cfg_valid && cfg_ready) begin
        writes_taken++;
        case (cfg_index)
          ppr_pkg::REG_SOURCE_FORMAT:  m_fmt = ppr_pkg::fmt_t'(cfg_data[1:0]);
          ppr_pkg::REG_PICTURE_WIDTH:  m_width = cfg_data;
          ppr_pkg::REG_PICTURE_HEIGHT: m_height = cfg_data;
          default: ;
        endcase
      end

      // Predict the pixels of each accepted byte transaction.
      if (in_valid && in_ready) begin
        items_taken++;
        n = expand_bytes(plane0_byte, plane1_byte);
        if (cur_known) begin
          // Replace the prediction with the hand-typed single pixel.
          repeat (n) void'(expected_px.pop_back());
          expected_px.push_back('{cur_rgb, 1'b1, cur_eof});
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when asked for one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_done) begin
      out_ready <= 1'b0;
      hold_done <= hold_done + 1;
      hold_left <= LONG_HOLD;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one byte pair and hold it until the block takes it. Random idle
  // cycles go in front; with no idle the next pair follows back to back.
  task automatic offer_bytes(logic [7:0] b0, logic [7:0] b1,
                             logic known, logic [23:0] rgb, logic eof);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    plane0_byte <= b0;
    plane1_byte <= b1;
    cur_known <= known;
    cur_rgb <= rgb;
    cur_eof <= eof;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every expected pixel has come out, then let
  // the pipeline settle.
  task automatic wait_pixels_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; only ever done with the block idle.
  task automatic write_setting(logic [1:0] idx, logic [10:0] val);
    wait_pixels_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Small sizes half of the time so frames end often; else an extreme or a random value.
  function automatic logic [10:0] pick_dim(int unsigned typ);
    case ($urandom_range(11))
      0:       return 11'd0;
      1:       return 11'd1;
      2:       return 11'd1024;
      3:       return 11'd1025;
      4:       return 11'd2047;
      5:       return 11'($urandom);
      default: return 11'($urandom_range(typ, 1));
    endcase
  endfunction

  task automatic add_cfg(logic [1:0] idx, logic [10:0] val);
    script.push_back('{1'b1, idx, val, 8'h00, 8'h00, 1'b0, 24'h0, 1'b0});
  endtask

  task automatic add_px(logic [7:0] b0, logic [7:0] b1,
                        logic known, logic [23:0] rgb, logic eof);
    script.push_back('{1'b0, 2'd0, 11'd0, b0, b1, known, rgb, eof});
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int unsigned p;
    int unsigned c;
    int unsigned i;

    // Directed script. With width and height forced to 1 every transaction
    // gives one pixel that also ends the frame, so those are typed in.
    add_px(8'hA5, 8'h00, 1'b0, '0, 1'b0);                  // reset defaults
    add_cfg(REG_SPARE, 11'h7FF);                           // no register here
    add_cfg(ppr_pkg::REG_PICTURE_WIDTH, 11'd0);            // zero acts as 1
    add_cfg(ppr_pkg::REG_PICTURE_HEIGHT, 11'd0);
    add_px(8'h80, 8'h00, 1'b1, ppr_pkg::RGB_BLACK, 1'b1);  // set bit is black
    add_px(8'h7F, 8'h00, 1'b1, ppr_pkg::RGB_WHITE, 1'b1);
    add_cfg(ppr_pkg::REG_SOURCE_FORMAT, {9'd0, ppr_pkg::FMT_DUAL});
    add_px(8'h80, 8'h00, 1'b1, ppr_pkg::RGB_DARK, 1'b1);
    add_px(8'h00, 8'h80, 1'b1, ppr_pkg::RGB_LIGHT, 1'b1);
    add_px(8'hFF, 8'hFF, 1'b1, ppr_pkg::RGB_BLACK, 1'b1);
    add_cfg(ppr_pkg::REG_SOURCE_FORMAT, {9'd0, ppr_pkg::FMT_PACKED});
    add_px(8'hE0, 8'h55, 1'b1, 24'hFFFFFF, 1'b1);          // low nibble dropped
    add_cfg(ppr_pkg::REG_SOURCE_FORMAT, {9'd0, ppr_pkg::FMT_RGB565});
    add_px(8'hFF, 8'hFF, 1'b1, 24'hF8FCF8, 1'b1);
    add_px(8'hF8, 8'h00, 1'b1, 24'hF80000, 1'b1);
    add_px(8'h07, 8'hE0, 1'b1, 24'h00FC00, 1'b1);
    add_px(8'h00, 8'h1F, 1'b1, 24'h0000F8, 1'b1);
    // Three-pixel frame of packed data: the second byte ends it on its high
    // nibble.
    add_cfg(ppr_pkg::REG_SOURCE_FORMAT, {9'd0, ppr_pkg::FMT_PACKED});
    add_cfg(ppr_pkg::REG_PICTURE_WIDTH, 11'd3);
    add_px(8'h8C, 8'h00, 1'b0, '0, 1'b0);
    add_px(8'h42, 8'h00, 1'b0, '0, 1'b0);
    add_cfg(ppr_pkg::REG_SOURCE_FORMAT, {9'd0, ppr_pkg::FMT_RGB565});
    add_px(8'h12, 8'h34, 1'b0, '0, 1'b0);
    // Oversize dimensions clamp; format bits above the field are ignored.
    add_cfg(ppr_pkg::REG_PICTURE_WIDTH, 11'd2047);
    add_cfg(ppr_pkg::REG_PICTURE_HEIGHT, 11'd1025);
    add_cfg(ppr_pkg::REG_SOURCE_FORMAT, {9'h1FF, ppr_pkg::FMT_DUAL});
    add_px(8'h00, 8'hFF, 1'b0, '0, 1'b0);
    // Width cut to 10 mid-row, then a format switch at a row start: each mono byte
    // still starts at its MSB and its padding past the row end is dropped.
    add_cfg(ppr_pkg::REG_PICTURE_WIDTH, 11'd10);
    add_px(8'h5A, 8'hC3, 1'b0, '0, 1'b0);
    add_cfg(ppr_pkg::REG_SOURCE_FORMAT, {9'd0, ppr_pkg::FMT_MONO});
    add_px(8'h3C, 8'h00, 1'b0, '0, 1'b0);
    add_px(8'hFF, 8'h00, 1'b0, '0, 1'b0);

    // Hold reset, then release it once at a clock edge.
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < script.size(); i++) begin
      if (script[i].is_cfg)
        write_setting(script[i].idx, script[i].data);
      else
        offer_bytes(script[i].b0, script[i].b1, script[i].known,
                    script[i].rgb, script[i].eof);
    end

    // Random part in three idle phases: sender-light, receiver-light, none.
    for (p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 36 : (p == 1) ? 66 : 0;
      rx_idle_pct <= (p == 0) ? 66 : (p == 1) ? 36 : 0;
      for (c = 0; c < 3; c++) begin
        write_setting(ppr_pkg::REG_SOURCE_FORMAT,
                      {9'($urandom), 2'($urandom_range(3))});
        if ($urandom_range(1) == 1)
          write_setting(ppr_pkg::REG_PICTURE_WIDTH, pick_dim(24));
        if ($urandom_range(1) == 1)
          write_setting(ppr_pkg::REG_PICTURE_HEIGHT, pick_dim(4));
        // Hold the receiver off for a long stretch while the sender keeps
        // offering, so the queue fills and input stalls.
        if (p == 2 && c == 0) hold_req <= hold_req + 1;
        in_valid <= 1'b0;
        @(posedge clk);
        repeat ((p == 2 && c == 0) ? 25 : 15)
          offer_bytes(8'($urandom), 8'($urandom), 1'b0, '0, 1'b0);
      end
    end

    wait_pixels_drained();
    repeat (16) @(posedge clk);

    $display("tb_top: %0d byte transactions, %0d pixels, %0d frame ends, %0d register writes",
             items_taken, px_taken, frames_seen, writes_taken);
    $display("tb_top: all four formats, clamped sizes, mid-row changes, backpressure");
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
